FILE: design/bpr_pkg.sv
// Shared types and constants of the bootloader packet receiver.
`default_nettype none
package bpr_pkg;

    localparam int MAX_DATA_DEF = 256;

    localparam logic [31:0] BASE_ADDR_RESET = 32'h0001_0000;
    localparam logic [7:0]  SYNC_FIRST      = 8'h55;
    localparam logic [7:0]  SYNC_SECOND     = 8'h5A;
    localparam logic [7:0]  ACK_BYTE        = 8'hAA;
    localparam logic [7:0]  SOP_BYTE        = 8'hAA;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        PH_HS1,
        PH_HS2,
        PH_HUNT,
        PH_NUM_H,
        PH_NUM_L,
        PH_SIZE_H,
        PH_SIZE_L,
        PH_DATA,
        PH_CSUM
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HS_ACK   = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_READ     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [31:0] write_address;
        logic [8:0]  packet_size;
        logic [15:0] packet_number;
        logic        session_done;
        logic [15:0] accepted_count;
        logic [7:0]  read_data;
    } t_result;

endpackage
`default_nettype wire

FILE: design/bpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: design/bpr_parser.sv
// Protocol state machine: handshake, header, data, checksum and session state.
`default_nettype none
module bpr_parser #(
    parameter int MAX_DATA = bpr_pkg::MAX_DATA_DEF,
    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_byte,
    input  wire logic [31:0]      i_base_address,
    output bpr_pkg::t_result      o_res,
    output logic                  o_res_valid,
    output logic                  o_wr_en,
    output logic      [AW-1:0]    o_wr_addr,
    output logic      [7:0]       o_wr_data
);
    import bpr_pkg::*;

    localparam int CW = $clog2(MAX_DATA + 1);

    t_phase      r_phase, n_phase;
    logic [15:0] r_number, n_number;
    logic [15:0] r_size, n_size;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_sum, n_sum;
    logic [31:0] r_next_addr, n_next_addr;
    logic [15:0] r_tally, n_tally;

    logic [7:0]    sum_add;
    logic [CW-1:0] cnt_inc;
    logic [15:0]   size_low;
    logic          short_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HS1;
            r_number    <= '0;
            r_size      <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_next_addr <= BASE_ADDR_RESET;
            r_tally     <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_number    <= n_number;
            r_size      <= n_size;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_next_addr <= n_next_addr;
            r_tally     <= n_tally;
        end
    end

    assign sum_add   = r_sum + i_byte;
    assign cnt_inc   = r_cnt + CW'(1);
    assign size_low  = {r_size[15:8], i_byte};
    assign short_pkt = {16'd0, r_size} < 32'(MAX_DATA);

    assign o_wr_en   = i_en && (r_phase == PH_DATA);
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_byte;

    always_comb begin
        n_phase     = r_phase;
        n_number    = r_number;
        n_size      = r_size;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_next_addr = r_next_addr;
        n_tally     = r_tally;
        o_res       = '0;
        o_res_valid = 1'b0;
        unique case (r_phase)
            PH_HS1: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_HS2;
                end
            end
            PH_HS2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase       = PH_HUNT;
                    n_next_addr   = i_base_address;
                    n_tally       = '0;
                    o_res.kind    = KIND_HS_ACK;
                    o_res.tx_byte = ACK_BYTE;
                    o_res_valid   = 1'b1;
                end else begin
                    n_phase = PH_HS1;
                end
            end
            PH_HUNT: begin
                if (i_byte == SOP_BYTE) begin
                    n_sum   = SOP_BYTE;
                    n_phase = PH_NUM_H;
                end
            end
            PH_NUM_H: begin
                n_number = {i_byte, 8'd0};
                n_sum    = sum_add;
                n_phase  = PH_NUM_L;
            end
            PH_NUM_L: begin
                n_number = {r_number[15:8], i_byte};
                n_sum    = sum_add;
                n_phase  = PH_SIZE_H;
            end
            PH_SIZE_H: begin
                n_size  = {i_byte, 8'd0};
                n_sum   = sum_add;
                n_phase = PH_SIZE_L;
            end
            PH_SIZE_L: begin
                n_size = size_low;
                n_sum  = sum_add;
                n_cnt  = '0;
                if ({16'd0, size_low} > 32'(MAX_DATA)) begin
                    n_phase             = PH_HUNT;
                    o_res.kind          = KIND_REJECTED;
                    o_res.packet_number = r_number;
                    o_res_valid         = 1'b1;
                end else if (size_low == 16'd0) begin
                    n_phase = PH_CSUM;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum = sum_add;
                n_cnt = cnt_inc;
                if (16'(cnt_inc) >= r_size) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                o_res_valid         = 1'b1;
                o_res.packet_number = r_number;
                if (r_size == 16'd0 || i_byte != r_sum) begin
                    n_phase    = PH_HUNT;
                    o_res.kind = KIND_REJECTED;
                end else begin
                    n_tally              = r_tally + 16'd1;
                    n_next_addr          = r_next_addr + {16'd0, r_size};
                    n_phase              = short_pkt ? PH_HS1 : PH_HUNT;
                    o_res.kind           = KIND_ACCEPTED;
                    o_res.tx_byte        = ACK_BYTE;
                    o_res.write_address  = r_next_addr;
                    o_res.packet_size    = r_size[8:0];
                    o_res.session_done   = short_pkt;
                    o_res.accepted_count = n_tally;
                end
            end
            default: begin
                n_phase = PH_HS1;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/bootloader_packet_receiver.sv
// Top level of the bootloader packet receiver: input stage, buffer RAM, result register.
// Input channel (i_in_valid / o_in_stall) carries one item per transfer: op 0 feeds a
// received serial byte into the protocol, op 1 reads a byte of the packet buffer.
// Output channel (o_out_valid / i_out_stall) carries one result per transfer: handshake
// ack, packet accepted, packet rejected, or buffer read data. Bytes that cause no
// result produce no output transfer.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes base_address; ready is
// always high. Write it only while the block is idle.
// The input register captures each input transfer, and the result register loads its result
// from there unless the output is stalled. Throughput: one item per cycle while the output is
// not stalled; the buffer RAM read port is addressed at the input transfer, its registered data
// used while the item is in the input register.
// A stall on the output holds a waiting result in the result register; an empty input
// register still takes one more item, and o_in_stall stays high while the input
// register is full and the waiting result is stalled.
// Reset (i_rst_n low, synchronous) returns the protocol to waiting for the first
// handshake byte, base_address and the next write address to 0x00010000, and clears
// all counters. Buffer contents are not cleared and are undefined until written.
`default_nettype none
module bootloader_packet_receiver #(
    parameter int MAX_DATA = bpr_pkg::MAX_DATA_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [1:0]  o_kind,
    output logic      [7:0]  o_tx_byte,
    output logic      [31:0] o_write_address,
    output logic      [8:0]  o_packet_size,
    output logic      [15:0] o_packet_number,
    output logic             o_session_done,
    output logic      [15:0] o_accepted_count,
    output logic      [7:0]  o_read_data
);
    import bpr_pkg::*;

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    logic [31:0] r_base;

    logic        r_s1_valid;
    logic        r_s1_op;
    logic [7:0]  r_s1_byte;
    logic        r_s1_in_range;
    logic        r_byp_hit;
    logic [7:0]  r_byp_data;

    logic        r_out_valid;
    t_result     r_out;

    logic          advance;
    logic          accept;
    logic          parse_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_byte;
    t_result       parse_res;
    logic          parse_res_valid;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    t_result       s1_res;
    logic          s1_res_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;
    assign parse_en   = r_s1_valid && advance && (r_s1_op == OP_RX);

    assign rd_addr = AW'(i_read_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= i_op;
            r_s1_byte     <= i_rx_byte;
            r_s1_in_range <= {24'd0, i_read_index} < 32'(MAX_DATA);
            r_byp_hit     <= wr_en && (wr_addr == rd_addr);
            r_byp_data    <= wr_data;
        end
    end

    bpr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    bpr_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (parse_en),
        .i_byte         (r_s1_byte),
        .i_base_address (r_base),
        .o_res          (parse_res),
        .o_res_valid    (parse_res_valid),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    always_comb begin
        rd_byte = 8'd0;
        if (r_s1_in_range) begin
            rd_byte = r_byp_hit ? r_byp_data : ram_rdata;
        end
    end

    always_comb begin
        if (r_s1_op == OP_READ) begin
            s1_res           = '0;
            s1_res.kind      = KIND_READ;
            s1_res.read_data = rd_byte;
            s1_res_valid     = 1'b1;
        end else begin
            s1_res       = parse_res;
            s1_res_valid = parse_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && s1_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out <= s1_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_tx_byte        = r_out.tx_byte;
    assign o_write_address  = r_out.write_address;
    assign o_packet_size    = r_out.packet_size;
    assign o_packet_number  = r_out.packet_number;
    assign o_session_done   = r_out.session_done;
    assign o_accepted_count = r_out.accepted_count;
    assign o_read_data      = r_out.read_data;

endmodule
`default_nettype wire
